>>> hdl/bezier_subdivide_at_t_assert.svh
// Assertion macros used by the checker file.
`ifndef BEZIER_SUBDIVIDE_AT_T_ASSERT_SVH
`define BEZIER_SUBDIVIDE_AT_T_ASSERT_SVH

// Implication in the same cycle.
`define BSAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define BSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bsat_pkg.sv
`default_nettype none
package bsat_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int T_FRACTION_BITS = 16;
    localparam int IDX_WIDTH       = 3;

    // Length of the output shift line: the longest run of points.
    localparam int SHIFT_DEPTH     = 7;

    localparam logic OP_QUAD  = 1'b0;
    localparam logic OP_CUBIC = 1'b1;

    localparam logic [IDX_WIDTH-1:0] QUAD_POINTS  = 3'd5;
    localparam logic [IDX_WIDTH-1:0] CUBIC_POINTS = 3'd7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [T_FRACTION_BITS-1:0]    tfrac_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // Everything one segment carries down the pipeline.
    typedef struct packed {
        logic   op;
        tfrac_t t;
        point_t p0;
        point_t p2;
        point_t p3;
        point_t a;
        point_t b;
        point_t c;
        point_t ab;
        point_t bc;
        point_t mid;
    } seg_t;

    // a + floor((b - a) * t / 2^T_FRACTION_BITS) with a one-bit-wider difference.
    function automatic coord_t lerp1(input coord_t a, input coord_t b, input tfrac_t t);
        logic signed [COORD_WIDTH:0]                   d;
        logic signed [COORD_WIDTH+T_FRACTION_BITS+1:0] prod;
        begin
            d    = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
            prod = d * $signed({1'b0, t});
            return a + coord_t'(prod[COORD_WIDTH+T_FRACTION_BITS-1:T_FRACTION_BITS]);
        end
    endfunction

    function automatic point_t lerp_pt(input point_t a, input point_t b, input tfrac_t t);
        point_t r;
        begin
            r.x = lerp1(a.x, b.x, t);
            r.y = lerp1(a.y, b.y, t);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/bsat_in_if.sv
`default_nettype none
interface bsat_in_if;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p0_x;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p0_y;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p1_x;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p1_y;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p2_x;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p2_y;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p3_x;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] p3_y;
    logic [bsat_pkg::T_FRACTION_BITS-1:0]    split_t;

    modport source (output valid, opcode, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                    p3_x, p3_y, split_t, input ready);
    modport sink (input valid, opcode, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                  p3_x, p3_y, split_t, output ready);
endinterface
`default_nettype wire

>>> hdl/bsat_out_if.sv
`default_nettype none
interface bsat_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [bsat_pkg::IDX_WIDTH-1:0]          point_index;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] out_x;
    logic signed [bsat_pkg::COORD_WIDTH-1:0] out_y;
    logic                                    last_point;

    modport source (output valid, point_index, out_x, out_y, last_point, input ready);
    modport sink (input valid, point_index, out_x, out_y, last_point, output ready);
endinterface
`default_nettype wire

>>> hdl/bsat_pipe.sv
`default_nettype none
module bsat_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bsat_in_if.sink            in_ch,
    output bsat_pkg::seg_t     seg,
    output logic               seg_valid,
    input  wire logic          seg_ready
);
    import bsat_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    seg_t s1_reg, s2_reg, s3_reg;
    seg_t s1_next, s2_next, s3_next;
    point_t p1;

    // Each stage loads when it is empty or its contents move on.
    assign en3 = !v3_reg || seg_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ch.ready = en1;

    // First level: a, b, c straight from the input beat.
    always_comb
    begin
        p1           = '{x: in_ch.p1_x, y: in_ch.p1_y};
        s1_next      = '0;
        s1_next.op   = in_ch.opcode;
        s1_next.t    = in_ch.split_t;
        s1_next.p0   = '{x: in_ch.p0_x, y: in_ch.p0_y};
        s1_next.p2   = '{x: in_ch.p2_x, y: in_ch.p2_y};
        s1_next.p3   = '{x: in_ch.p3_x, y: in_ch.p3_y};
        s1_next.a    = lerp_pt(s1_next.p0, p1, s1_next.t);
        s1_next.b    = lerp_pt(p1, s1_next.p2, s1_next.t);
        s1_next.c    = lerp_pt(s1_next.p2, s1_next.p3, s1_next.t);
    end

    // Second level: ab and bc.
    always_comb
    begin
        s2_next    = s1_reg;
        s2_next.ab = lerp_pt(s1_reg.a, s1_reg.b, s1_reg.t);
        s2_next.bc = lerp_pt(s1_reg.b, s1_reg.c, s1_reg.t);
    end

    // Third level: the point on the curve.
    always_comb
    begin
        s3_next     = s2_reg;
        s3_next.mid = lerp_pt(s2_reg.ab, s2_reg.bc, s2_reg.t);
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_ch.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign seg       = s3_reg;
    assign seg_valid = v3_reg;

endmodule
`default_nettype wire

>>> hdl/bsat_ser.sv
`default_nettype none
module bsat_ser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bsat_pkg::seg_t seg,
    input  wire logic          seg_valid,
    output logic               seg_ready,
    bsat_out_if.source         out_ch
);
    import bsat_pkg::*;

    point_t                 buf_reg [SHIFT_DEPTH];
    point_t                 load_pts [SHIFT_DEPTH];
    logic [IDX_WIDTH-1:0]   cnt_reg;
    logic [IDX_WIDTH-1:0]   idx_reg;
    logic                   fire;
    logic                   load;

    assign fire      = out_ch.valid && out_ch.ready;
    assign seg_ready = (cnt_reg == '0) || (cnt_reg == 3'd1 && out_ch.ready);
    assign load      = seg_valid && seg_ready;

    // Arrange the split control sequence for the shift line.
    always_comb
    begin
        load_pts[0] = seg.p0;
        load_pts[1] = seg.a;
        load_pts[2] = seg.ab;
        if (seg.op == OP_CUBIC)
        begin
            load_pts[3] = seg.mid;
            load_pts[4] = seg.bc;
            load_pts[5] = seg.c;
            load_pts[6] = seg.p3;
        end
        else
        begin
            load_pts[3] = seg.b;
            load_pts[4] = seg.p2;
            load_pts[5] = seg.p2;
            load_pts[6] = seg.p2;
        end
    end

    // Remaining count and point index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= (seg.op == OP_CUBIC) ? CUBIC_POINTS : QUAD_POINTS;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Shift line: the head is the current beat.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < SHIFT_DEPTH; i++)
            begin
                buf_reg[i] <= load_pts[i];
            end
        end
        else if (fire)
        begin
            for (int i = 0; i < SHIFT_DEPTH - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign out_ch.valid       = (cnt_reg != '0);
    assign out_ch.point_index = idx_reg;
    assign out_ch.out_x       = buf_reg[0].x;
    assign out_ch.out_y       = buf_reg[0].y;
    assign out_ch.last_point  = (cnt_reg == 3'd1);

endmodule
`default_nettype wire

>>> hdl/bezier_subdivide_at_t.sv
// Path: an accepted beat passes stages s1, s2 and s3, then is loaded into the output line.
// Throughput: one point per cycle while out_ch.ready is high, five points per quadratic
// and seven per cubic; the output shift line, one point per beat, sets that rate.
// The three interpolation stages accept a new segment every cycle while they have room.
// Reset (rst_n, asynchronous, active low) empties every stage and the output line.
`default_nettype none
module bezier_subdivide_at_t (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsat_in_if.sink    in_ch,
    bsat_out_if.source out_ch
);
    import bsat_pkg::*;

    seg_t seg;
    logic seg_valid;
    logic seg_ready;

    // Three-stage de Casteljau interpolation.
    bsat_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .seg       (seg),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready)
    );

    // Point-by-point output.
    bsat_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

>>> hdl/bsat_checker.sv
`default_nettype none
`include "bezier_subdivide_at_t_assert.svh"
module bsat_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] point_index,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y,
    input wire logic       last_point
);

    // A stalled beat holds.
    `BSAT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(point_index) && $stable(last_point), "stalled beat changed")

    // Within a run the index counts up by one.
    `BSAT_ASSERT_NEXT(a_step, clk, rst_n, out_valid && out_ready && !last_point, out_valid && point_index == 3'($past(point_index) + 3'd1), "index did not advance")

    // A run ends only after five or seven points.
    `BSAT_ASSERT_NOW(a_last, clk, rst_n, out_valid && last_point, point_index == 3'd4 || point_index == 3'd6, "bad run length")

    // A new run starts at index zero.
    `BSAT_ASSERT_NEXT(a_start, clk, rst_n, out_valid && out_ready && last_point, !out_valid || point_index == 3'd0, "run did not restart")

endmodule

bind bezier_subdivide_at_t bsat_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .point_index (out_ch.point_index),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y),
    .last_point  (out_ch.last_point)
);
`default_nettype wire
